// File: rtl/core/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared widths, status codes and interface structs of the sparse set engine.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int ENTITY_CAP = 1024;
	localparam int MAX_POOLS  = 8;

	localparam int SLOT_W  = $clog2(ENTITY_CAP);
	localparam int POOL_W  = $clog2(MAX_POOLS);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int ADDR_W  = POOL_W + SLOT_W;
	localparam int DEPTH   = MAX_POOLS * ENTITY_CAP;
	localparam int OP_W    = 2;
	localparam int ENT_W   = 16;
	localparam int NPOOL_W = 4;
	localparam int STAT_W  = 3;

	// Sparse entry: valid bit on top of the dense slot.
	localparam int SPARSE_W = SLOT_W + 1;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NO_POOL = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DUP_ABS = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

	localparam logic [0:0] REG_NUM_POOLS    = 1'd0;
	localparam logic [0:0] REG_ENTITY_LIMIT = 1'd1;

	typedef struct packed {
		logic [NPOOL_W-1:0] num_pools;
		logic [CNT_W-1:0]   entity_limit;
	} cfg_t;

	typedef struct packed {
		logic                sp_re;
		logic [ADDR_W-1:0]   sp_raddr;
		logic                sp_we;
		logic [ADDR_W-1:0]   sp_waddr;
		logic [SPARSE_W-1:0] sp_wdata;
		logic                dn_re;
		logic [ADDR_W-1:0]   dn_raddr;
		logic                dn_we;
		logic [ADDR_W-1:0]   dn_waddr;
		logic [SLOT_W-1:0]   dn_wdata;
	} mem_req_t;

	typedef struct packed {
		logic                busy;
		logic [SPARSE_W-1:0] sp_rdata;
		logic [SLOT_W-1:0]   dn_rdata;
	} mem_rsp_t;

endpackage

// File: rtl/core/sparse_set_membership.sv
// Sequence: an accepted word passes the check step (table read), then the decide
// step; a new word is accepted only back in idle, after the last word's decide
// step; a successful remove also passes a fix step to clear its sparse entry.
// A result held back by m_tready low keeps the sequencer in its decide step.
// Reset: pool counts and registers reset at once; a clearing pass then writes
// all 8192 sparse entries empty, and s_tready stays low until the pass ends.
// ----------------------------------------------------------------------------
// sparse_set_membership
// Add, remove and query of entities in several sparse sets with swap-remove.
// ----------------------------------------------------------------------------
module sparse_set_membership (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [10:0] wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // operation[1:0], pool[4:2], entity[20:5], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // success[0], status[3:1], dense_slot[13:4],
	                               // pool_count[24:14], zero
);
	import ssm_pkg::*;

	cfg_t     cfg_q;
	mem_req_t req;
	mem_rsp_t rsp;

	logic              out_success;
	logic [STAT_W-1:0] out_status;
	logic [SLOT_W-1:0] out_slot;
	logic [CNT_W-1:0]  out_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_pools    <= NPOOL_W'(MAX_POOLS);
			cfg_q.entity_limit <= CNT_W'(ENTITY_CAP);
		end else if (wr_en) begin
			case (wr_index)
				REG_NUM_POOLS:    cfg_q.num_pools    <= wr_data[NPOOL_W-1:0];
				REG_ENTITY_LIMIT: cfg_q.entity_limit <= wr_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ssm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tdata[1:0]),
		.in_pool     (s_tdata[4:2]),
		.in_entity   (s_tdata[20:5]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_success (out_success),
		.out_status  (out_status),
		.out_slot    (out_slot),
		.out_count   (out_count),
		.req         (req),
		.rsp         (rsp)
	);

	ssm_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign m_tdata = {7'd0, out_count, out_slot, out_status, out_success};

endmodule

// File: rtl/core/ssm_store.sv
// ----------------------------------------------------------------------------
// ssm_store
// Sparse and dense tables of all pools, with the post-reset clearing sweep.
// ----------------------------------------------------------------------------
module ssm_store (
	input  logic              clk,
	input  logic              arst_n,
	input  ssm_pkg::mem_req_t req,
	output ssm_pkg::mem_rsp_t rsp
);
	import ssm_pkg::*;

	logic [SPARSE_W-1:0] sparse_mem [DEPTH];
	logic [SLOT_W-1:0]   dense_mem  [DEPTH];

	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic [SPARSE_W-1:0] sp_rdata_q;
	logic [SLOT_W-1:0]   dn_rdata_q;

	// After reset every sparse entry is written empty, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			sparse_mem[clr_addr_q] <= '0;
		end else if (req.sp_we) begin
			sparse_mem[req.sp_waddr] <= req.sp_wdata;
		end
		if (req.sp_re) begin
			sp_rdata_q <= sparse_mem[req.sp_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.dn_we) begin
			dense_mem[req.dn_waddr] <= req.dn_wdata;
		end
		if (req.dn_re) begin
			dn_rdata_q <= dense_mem[req.dn_raddr];
		end
	end

	assign rsp.busy     = clr_busy_q;
	assign rsp.sp_rdata = sp_rdata_q;
	assign rsp.dn_rdata = dn_rdata_q;

endmodule

// File: rtl/core/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl
// Operation sequencer: checks, table reads and writes, pool counts, result word.
// ----------------------------------------------------------------------------
module ssm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssm_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ssm_pkg::OP_W-1:0]    in_op,
	input  logic [ssm_pkg::POOL_W-1:0]  in_pool,
	input  logic [ssm_pkg::ENT_W-1:0]   in_entity,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_success,
	output logic [ssm_pkg::STAT_W-1:0]  out_status,
	output logic [ssm_pkg::SLOT_W-1:0]  out_slot,
	output logic [ssm_pkg::CNT_W-1:0]   out_count,
	output ssm_pkg::mem_req_t           req,
	input  ssm_pkg::mem_rsp_t           rsp
);
	import ssm_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_CHECK  = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;
	localparam logic [1:0] S_FIX    = 2'd3;

	logic [1:0]        state_q, state_nxt;
	logic [OP_W-1:0]   op_q;
	logic [POOL_W-1:0] pool_q;
	logic [ENT_W-1:0]  ent_q;
	logic [CNT_W-1:0]  pool_size_q [MAX_POOLS];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  last_q;
	logic              bad_pool_q, bad_range_q, full_q;

	logic              m_valid_q;
	logic              m_success_q;
	logic [STAT_W-1:0] m_status_q;
	logic [SLOT_W-1:0] m_slot_q;
	logic [CNT_W-1:0]  m_count_q;

	logic [NPOOL_W-1:0] pools_eff;
	logic [CNT_W-1:0]   lim_eff;
	logic [CNT_W-1:0]   cnt_sel;
	logic               out_free;
	logic               accept;

	logic              res_load;
	logic              res_success;
	logic [STAT_W-1:0] res_status;
	logic [SLOT_W-1:0] res_slot;
	logic [CNT_W-1:0]  res_count;
	logic              size_we;
	logic [CNT_W-1:0]  size_wdata;

	logic [SLOT_W-1:0] hit_slot;
	logic              hit_valid;

	function automatic logic [SLOT_W-1:0] last_of(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] d;
		d = c - 1'b1;
		return d[SLOT_W-1:0];
	endfunction

	assign pools_eff = (cfg.num_pools > NPOOL_W'(MAX_POOLS)) ?
		NPOOL_W'(MAX_POOLS) : cfg.num_pools;
	assign lim_eff = (cfg.entity_limit > CNT_W'(ENTITY_CAP)) ?
		CNT_W'(ENTITY_CAP) : cfg.entity_limit;
	assign cnt_sel   = pool_size_q[pool_q];
	assign out_free  = !m_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && !rsp.busy;
	assign accept    = in_valid && in_ready;
	assign hit_valid = rsp.sp_rdata[SPARSE_W-1];
	assign hit_slot  = rsp.sp_rdata[SLOT_W-1:0];

	always_comb begin
		state_nxt   = state_q;
		req         = '0;
		res_load    = 1'b0;
		res_success = 1'b0;
		res_status  = STAT_OK;
		res_slot    = '0;
		res_count   = cnt_q;
		size_we     = 1'b0;
		size_wdata  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				// The entity's sparse entry and the last dense entry are fetched together.
				req.sp_re    = 1'b1;
				req.sp_raddr = {pool_q, ent_q[SLOT_W-1:0]};
				req.dn_re    = 1'b1;
				req.dn_raddr = {pool_q, last_of(cnt_sel)};
				state_nxt    = S_DECIDE;
			end
			S_DECIDE: begin
				// Writes and the result wait until the output register can take it.
				if (out_free) begin
					res_load  = 1'b1;
					state_nxt = S_IDLE;
					if (bad_pool_q) begin
						res_status = STAT_NO_POOL;
						res_count  = '0;
					end else if (op_q == OP_NONE) begin
						res_status = STAT_OK;
					end else if (bad_range_q) begin
						res_status = STAT_RANGE;
					end else if (op_q == OP_ADD) begin
						if (hit_valid) begin
							res_status = STAT_DUP_ABS;
						end else if (full_q) begin
							res_status = STAT_FULL;
						end else begin
							req.sp_we    = 1'b1;
							req.sp_waddr = {pool_q, ent_q[SLOT_W-1:0]};
							req.sp_wdata = {1'b1, cnt_q[SLOT_W-1:0]};
							req.dn_we    = 1'b1;
							req.dn_waddr = {pool_q, cnt_q[SLOT_W-1:0]};
							req.dn_wdata = ent_q[SLOT_W-1:0];
							size_we      = 1'b1;
							size_wdata   = cnt_q + 1'b1;
							res_success  = 1'b1;
							res_slot     = cnt_q[SLOT_W-1:0];
							res_count    = cnt_q + 1'b1;
						end
					end else if (!hit_valid || cnt_q == '0) begin
						res_status = STAT_DUP_ABS;
					end else if (op_q == OP_QUERY) begin
						res_success = 1'b1;
						res_slot    = hit_slot;
					end else begin
						// Remove: the last member moves into the vacated slot.
						if ({1'b0, hit_slot} != last_q) begin
							req.dn_we    = 1'b1;
							req.dn_waddr = {pool_q, hit_slot};
							req.dn_wdata = rsp.dn_rdata;
							req.sp_we    = 1'b1;
							req.sp_waddr = {pool_q, rsp.dn_rdata};
							req.sp_wdata = {1'b1, hit_slot};
						end
						size_we     = 1'b1;
						size_wdata  = last_q;
						res_success = 1'b1;
						res_slot    = hit_slot;
						res_count   = last_q;
						state_nxt   = S_FIX;
					end
				end
			end
			S_FIX: begin
				req.sp_we    = 1'b1;
				req.sp_waddr = {pool_q, ent_q[SLOT_W-1:0]};
				req.sp_wdata = '0;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			for (int i = 0; i < MAX_POOLS; i++) begin
				pool_size_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
			if (size_we) begin
				pool_size_q[pool_q] <= size_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			pool_q <= in_pool;
			ent_q  <= in_entity;
		end
		if (state_q == S_CHECK) begin
			cnt_q       <= cnt_sel;
			last_q      <= cnt_sel - 1'b1;
			bad_pool_q  <= {1'b0, pool_q} >= pools_eff;
			bad_range_q <= ent_q >= {{(ENT_W-CNT_W){1'b0}}, lim_eff};
			full_q      <= cnt_sel >= lim_eff;
		end
		if (res_load) begin
			m_success_q <= res_success;
			m_status_q  <= res_status;
			m_slot_q    <= res_slot;
			m_count_q   <= res_count;
		end
	end

	assign out_valid   = m_valid_q;
	assign out_success = m_success_q;
	assign out_status  = m_status_q;
	assign out_slot    = m_slot_q;
	assign out_count   = m_count_q;

endmodule

// File: rtl/core/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks of the sparse set engine, bound to the top level.
// ----------------------------------------------------------------------------
module ssm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	import ssm_pkg::*;

	// A held result word must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// The sequencer works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word is in flight");

	// A successful result always carries the ok status.
	a_success_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[3:1] == STAT_OK)
		else $error("success with a failure status");

	// A failed result reports slot zero.
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[13:4] == '0)
		else $error("failed result with a nonzero slot");

endmodule

bind sparse_set_membership ssm_checker u_ssm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: sim/sparse_set_membership_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_set_membership_tb
// Drives add, remove and query words into the sparse set engine and checks
// every result word against an in-bench model of the pools. It models the
// sparse and dense tables and the member counts. A directed opening covers
// the status codes, swap-remove and the register corner cases. Random phases
// follow under several pool and limit settings, with random gaps and stalls
// on both streams in all but the last, quiet phase.
// ----------------------------------------------------------------------------
module sparse_set_membership_tb;

	import ssm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic              success;
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [0:0]  wr_index = '0;
	logic [10:0] wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // operation[1:0], pool[4:2], entity[20:5], zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // success[0], status[3:1], dense_slot[13:4],
	                             // pool_count[24:14], zero

	sparse_set_membership dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Pool state as the engine should hold it.
	logic               in_set   [DEPTH];
	logic [SLOT_W-1:0]  slot_of  [DEPTH];
	logic [SLOT_W-1:0]  entity_at[DEPTH];
	logic [CNT_W-1:0]   members  [MAX_POOLS];
	logic [NPOOL_W-1:0] cfg_pools;
	logic [CNT_W-1:0]   cfg_limit;

	logic [23:0] pending[$];
	result_t     outstanding[$];
	int          send_gap = 0;
	int          stall_left = 0;
	int          fail_count = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	function automatic result_t membership_step(logic [OP_W-1:0] op, logic [POOL_W-1:0] p,
			logic [ENT_W-1:0] ent);
		result_t r;
		int pools, lim, cnt, base, idx, slot, last, moved;
		r = '0;
		pools = (cfg_pools > MAX_POOLS) ? MAX_POOLS : int'(cfg_pools);
		lim = (cfg_limit > ENTITY_CAP) ? ENTITY_CAP : int'(cfg_limit);
		if (int'(p) >= pools) begin
			r.status = STAT_NO_POOL;
			return r;
		end
		cnt = int'(members[p]);
		r.count = CNT_W'(cnt);
		if (op == OP_NONE)
			return r;
		if (int'(ent) >= lim) begin
			r.status = STAT_RANGE;
			return r;
		end
		base = int'(p) * ENTITY_CAP;
		idx = base + int'(ent);
		if (op == OP_ADD) begin
			if (in_set[idx]) begin
				r.status = STAT_DUP_ABS;
			end else if (cnt >= lim) begin
				r.status = STAT_FULL;
			end else begin
				in_set[idx] = 1'b1;
				slot_of[idx] = SLOT_W'(cnt);
				entity_at[base + cnt] = ent[SLOT_W-1:0];
				members[p] = CNT_W'(cnt + 1);
				r.success = 1'b1;
				r.slot = SLOT_W'(cnt);
				r.count = CNT_W'(cnt + 1);
			end
			return r;
		end
		if (!in_set[idx] || cnt == 0) begin
			r.status = STAT_DUP_ABS;
			return r;
		end
		slot = int'(slot_of[idx]);
		r.success = 1'b1;
		r.slot = SLOT_W'(slot);
		if (op == OP_QUERY)
			return r;
		// Swap-remove: the last member takes over the vacated slot.
		last = cnt - 1;
		if (slot != last) begin
			moved = int'(entity_at[base + last]);
			entity_at[base + slot] = SLOT_W'(moved);
			in_set[base + moved] = 1'b1;
			slot_of[base + moved] = SLOT_W'(slot);
		end
		in_set[idx] = 1'b0;
		members[p] = CNT_W'(last);
		r.count = CNT_W'(last);
		return r;
	endfunction

	function automatic void report_mismatch(string field, int want_v, int got_v);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
	endfunction

	function automatic void queue_word(logic [OP_W-1:0] op, logic [POOL_W-1:0] p,
			logic [ENT_W-1:0] ent);
		pending.insert(pending.size(), {3'b000, ent, p, op});
	endfunction

	// Mostly a small working set of entities so that adds, duplicates and
	// removes meet each other, with some words anywhere in the field.
	function automatic logic [23:0] random_word();
		int pools, lim, span, r;
		logic [OP_W-1:0]   op;
		logic [POOL_W-1:0] p;
		logic [ENT_W-1:0]  ent;
		pools = (cfg_pools > MAX_POOLS) ? MAX_POOLS : int'(cfg_pools);
		lim = (cfg_limit > ENTITY_CAP) ? ENTITY_CAP : int'(cfg_limit);
		span = (lim < 48) ? lim : 48;
		if (span < 1)
			span = 1;
		r = $urandom_range(0, 99);
		op = (r < 45) ? OP_ADD : (r < 72) ? OP_REMOVE : (r < 96) ? OP_QUERY : OP_NONE;
		if (pools == 0 || $urandom_range(0, 9) == 0)
			p = POOL_W'($urandom_range(0, 7));
		else
			p = POOL_W'($urandom_range(0, pools - 1));
		r = $urandom_range(0, 19);
		if (r == 0)
			ent = ENT_W'($urandom_range(0, 65535));
		else if (r < 3 && lim > 0)
			ent = ENT_W'($urandom_range(0, lim - 1));
		else
			ent = ENT_W'($urandom_range(0, span - 1));
		return {3'b000, ent, p, op};
	endfunction

	task automatic settle();
		do @(negedge clk);
		while (pending.size() != 0 || s_tvalid || outstanding.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx == REG_NUM_POOLS)
			cfg_pools = val[NPOOL_W-1:0];
		else
			cfg_limit = val[CNT_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_regs(input logic [10:0] pools, input logic [10:0] limit);
		settle();
		write_reg(REG_NUM_POOLS, pools);
		write_reg(REG_ENTITY_LIMIT, limit);
	endtask

	task automatic random_phase(input logic [10:0] pools, input logic [10:0] limit,
			input int n);
		set_regs(pools, limit);
		repeat (n) pending.insert(pending.size(), random_word());
	endtask

	// Sender: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				outstanding.insert(outstanding.size(),
					membership_step(s_tdata[1:0], s_tdata[4:2], s_tdata[20:5]));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 9);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata <= pending.pop_front();
					s_tvalid <= 1'b1;
				end
			end
		end
	end

	// Receiver: checks each result word and stalls in random bursts.
	always @(posedge clk) begin
		result_t want, got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[3:1], m_tdata[13:4], m_tdata[24:14]};
				if (outstanding.size() == 0) begin
					report_mismatch("unexpected result word", 0, 1);
				end else begin
					want = outstanding.pop_front();
					if (got.success !== want.success)
						report_mismatch("success", int'(want.success), int'(got.success));
					if (got.status !== want.status)
						report_mismatch("status", int'(want.status), int'(got.status));
					if (got.slot !== want.slot)
						report_mismatch("dense_slot", int'(want.slot), int'(got.slot));
					if (got.count !== want.count)
						report_mismatch("pool_count", int'(want.count), int'(got.count));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sparse_set_membership_tb: FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			in_set[i] = 1'b0;
			slot_of[i] = '0;
			entity_at[i] = '0;
		end
		for (int i = 0; i < MAX_POOLS; i++)
			members[i] = '0;
		cfg_pools = 4'd8;
		cfg_limit = 11'd1024;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Status codes, the field extremes and swap-remove at reset settings.
		queue_word(OP_QUERY, 3'd0, 16'd0);
		queue_word(OP_ADD, 3'd0, 16'd0);
		queue_word(OP_ADD, 3'd0, 16'd0);
		queue_word(OP_ADD, 3'd0, 16'd1023);
		queue_word(OP_ADD, 3'd0, 16'd1024);
		queue_word(OP_ADD, 3'd0, 16'hFFFF);
		queue_word(OP_NONE, 3'd0, 16'd0);
		queue_word(OP_QUERY, 3'd0, 16'd1023);
		queue_word(OP_REMOVE, 3'd0, 16'd0);
		queue_word(OP_QUERY, 3'd0, 16'd1023);
		queue_word(OP_REMOVE, 3'd0, 16'd0);
		queue_word(OP_REMOVE, 3'd0, 16'd1023);
		queue_word(OP_ADD, 3'd7, 16'h02AA);
		queue_word(OP_ADD, 3'd7, 16'h0155);
		queue_word(OP_ADD, 3'd2, 16'd10);
		queue_word(OP_ADD, 3'd2, 16'd11);
		queue_word(OP_ADD, 3'd2, 16'd12);
		queue_word(OP_QUERY, 3'd5, 16'h03FF);

		set_regs(11'd5, 11'd1024);
		queue_word(OP_ADD, 3'd6, 16'd1);
		queue_word(OP_NONE, 3'd7, 16'd0);
		queue_word(OP_NONE, 3'd4, 16'd0);
		set_regs(11'd0, 11'd1024);
		queue_word(OP_QUERY, 3'd0, 16'd0);
		// Out-of-range register values act as the largest sizes.
		set_regs(11'd15, 11'd1024);
		queue_word(OP_ADD, 3'd7, 16'd1);
		set_regs(11'd15, 11'd0);
		queue_word(OP_ADD, 3'd0, 16'd0);
		set_regs(11'd15, 11'd2047);
		queue_word(OP_ADD, 3'd0, 16'd1023);
		// Pool two already holds more members than the lowered limit allows.
		set_regs(11'd15, 11'd2);
		queue_word(OP_ADD, 3'd2, 16'd0);
		queue_word(OP_REMOVE, 3'd2, 16'd10);
		queue_word(OP_QUERY, 3'd2, 16'd1);

		random_phase(11'd8, 11'd1024, 250);
		random_phase(11'd3, 11'd16, 250);
		random_phase(11'd8, 11'd6, 250);
		random_phase(11'd15, 11'd2047, 250);
		random_phase(11'd2, 11'd1, 250);
		random_phase(11'd7, 11'd64, 250);
		settle();
		quiet = 1'b1;
		random_phase(11'd8, 11'd1024, 250);
		settle();

		if (fail_count == 0)
			$display("sparse_set_membership_tb: PASS");
		else
			$display("sparse_set_membership_tb: FAIL");
		$finish;
	end

endmodule
